/* rtl/core/bpc_pkg.sv */
package bpc_pkg;

	localparam int unsigned TimeWidth = 32;
	localparam int unsigned RegWidth  = 16;
	localparam int unsigned IndexWidth = 2;

	localparam logic [RegWidth-1:0] LongHoldReset = 16'd5000;
	localparam logic [RegWidth-1:0] MinPressReset = 16'd60;
	localparam logic [RegWidth-1:0] CooldownReset = 16'd300;

	localparam logic [IndexWidth-1:0] RegLongHold = 2'd0;
	localparam logic [IndexWidth-1:0] RegMinPress = 2'd1;
	localparam logic [IndexWidth-1:0] RegCooldown = 2'd2;

	typedef struct packed {
		logic [TimeWidth-1:0] time_ms;
		logic                 button_down;
	} sample_t;

	typedef struct packed {
		logic long_press;
		logic short_press;
		logic mode;
		logic held;
	} result_t;

	typedef struct packed {
		logic                 tracking;
		logic [TimeWidth-1:0] press_start;
		logic                 long_done;
		logic [TimeWidth-1:0] last_toggle;
		logic                 mode_bit;
	} press_state_t;

	typedef struct packed {
		logic [RegWidth-1:0] long_hold_time;
		logic [RegWidth-1:0] min_press_time;
		logic [RegWidth-1:0] toggle_cooldown;
	} settings_t;

endpackage

/* rtl/core/bpc_eval.sv */
module bpc_eval
	import bpc_pkg::*;
(
	input  sample_t      sample,
	input  press_state_t cur,
	input  settings_t    cfg,
	output press_state_t nxt,
	output result_t      result
);

	logic                 start;
	logic                 tracking_a;
	logic [TimeWidth-1:0] start_a;
	logic                 long_done_a;
	logic [TimeWidth-1:0] hold;
	logic [TimeWidth-1:0] since_toggle;
	logic                 long_fire;
	logic                 release_ev;
	logic                 short_fire;

	// The press edge is handled first, then the long-press check, then the release.
	assign start        = sample.button_down && !cur.tracking;
	assign tracking_a   = cur.tracking || start;
	assign start_a      = start ? sample.time_ms : cur.press_start;
	assign long_done_a  = start ? 1'b0 : cur.long_done;
	assign hold         = sample.time_ms - start_a;
	assign since_toggle = sample.time_ms - cur.last_toggle;

	assign long_fire = tracking_a && sample.button_down && !long_done_a
		&& (hold >= {{(TimeWidth-RegWidth){1'b0}}, cfg.long_hold_time});
	assign release_ev = tracking_a && !sample.button_down;
	assign short_fire = release_ev && !long_done_a
		&& (hold >= {{(TimeWidth-RegWidth){1'b0}}, cfg.min_press_time})
		&& (since_toggle > {{(TimeWidth-RegWidth){1'b0}}, cfg.toggle_cooldown});

	always_comb begin
		nxt.tracking    = tracking_a && sample.button_down;
		nxt.press_start = start_a;
		nxt.long_done   = long_done_a || long_fire;
		nxt.last_toggle = short_fire ? sample.time_ms : cur.last_toggle;
		nxt.mode_bit    = cur.mode_bit ^ short_fire;
		result.long_press  = long_fire;
		result.short_press = short_fire;
		result.mode        = nxt.mode_bit;
		result.held        = nxt.tracking;
	end

endmodule

/* rtl/core/button_press_classifier_core.sv */
// Channel  Dir  Handshake                    Payload
// sample   in   sample_valid / sample_stall  sample_t (time_ms, button_down)
// result   out  result_valid / result_stall  result_t (long_press, short_press, mode, held)
// config   in   cfg_we, cfg_index            cfg_data (16-bit register value)
//
// A sample is registered on transfer and evaluated against the press state from the
// sample register; its result is registered when the result side advances.
// One sample per cycle is taken while the result side does not stall.
// A stalled result holds; the sample register fills and then stalls the input.
// Reset clears the press state and the valid flags and loads the default settings.
module button_press_classifier_core
	import bpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [IndexWidth-1:0] cfg_index,
	input  logic [RegWidth-1:0]   cfg_data
);

	logic         valid_s1;
	sample_t      sample_s1;
	logic         advance;
	press_state_t state_q;
	press_state_t state_nxt;
	settings_t    cfg_q;
	result_t      result_nxt;

	assign advance      = !result_valid || !result_stall;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_hold_time  <= LongHoldReset;
			cfg_q.min_press_time  <= MinPressReset;
			cfg_q.toggle_cooldown <= CooldownReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLongHold: cfg_q.long_hold_time  <= cfg_data;
				RegMinPress: cfg_q.min_press_time  <= cfg_data;
				RegCooldown: cfg_q.toggle_cooldown <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	bpc_eval u_eval (
		.sample (sample_s1),
		.cur    (state_q),
		.cfg    (cfg_q),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result <= result_nxt;
		end
	end

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1)
		else $error("input stalled with an empty sample register");

	a_press_kinds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.long_press && result.short_press))
		else $error("long and short press in one result");

	a_long_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.long_press) |-> result.held)
		else $error("long press reported without a held button");

	a_short_ends_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.short_press) |-> !result.held)
		else $error("short press reported while still held");

	a_toggle_time: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && result_nxt.short_press)
		|=> (state_q.last_toggle == $past(sample_s1.time_ms)
			&& result.mode == state_q.mode_bit))
		else $error("toggle time or mode not recorded");

endmodule
